// File: src/hfc_pkg.sv
`timescale 1ns / 1ps

package hfc_pkg;

    localparam int KEY_W      = 32;
    localparam int OUT_W      = 32;
    localparam int HASH_STEPS = 2;
    localparam int STEP_W     = $clog2(HASH_STEPS);

    typedef struct packed {
        logic clear_write;
        logic load_key;
        logic hash_step;
        logic mem_read;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

// File: src/hfc_ctrl.sv
`timescale 1ns / 1ps

module hfc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  hfc_pkg::status_t status,
    output hfc_pkg::cmd_t   cmd,
    output logic            busy
);

    import hfc_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_HASH   = 5'b00100,
        S_READ   = 5'b01000,
        S_UPDATE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_key = 1'b1;
                    step_next    = '0;
                    state_next   = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(HASH_STEPS - 1))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: src/hfc_dp.sv
`timescale 1ns / 1ps

module hfc_dp #(
    parameter int BUCKETS    = 1021,
    parameter int WAYS       = 4,
    parameter int COUNT_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hfc_pkg::cmd_t              cmd,
    output hfc_pkg::status_t           status,
    input  logic [hfc_pkg::KEY_W-1:0]  key,
    output logic                       done,
    output logic [hfc_pkg::OUT_W-1:0]  count,
    output logic                       is_new,
    output logic                       overflow
);

    import hfc_pkg::*;

    localparam int RW      = $clog2(BUCKETS);
    localparam int WAY_W   = 1 + KEY_W + COUNT_BITS;
    localparam int ROW_W   = WAYS * WAY_W;
    localparam int SHIFT   = KEY_W + RW;
    localparam int RECIP_W = KEY_W + 1;
    localparam int PROD_W  = KEY_W + RECIP_W;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_WIDE);
    localparam logic [KEY_W-1:0]   BUCKETS_K = KEY_W'(BUCKETS);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] mag_reg;
    logic [KEY_W-1:0] quot_reg;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    clr_reg;
    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0] diff;

    logic [ROW_W-1:0] mem [BUCKETS];
    logic [ROW_W-1:0] rdata_reg;
    logic [ROW_W-1:0] wrow;
    logic             we;
    logic [RW-1:0]    waddr;
    logic [ROW_W-1:0] wdata;

    logic [WAYS-1:0]       hit_oh;
    logic [WAYS-1:0]       free_oh;
    logic                  any_hit;
    logic                  any_free;
    logic [COUNT_BITS-1:0] hit_count;
    logic [OUT_W-1:0]      hit_count_out;

    logic                  done_reg;
    logic [OUT_W-1:0]      count_reg;
    logic                  is_new_reg;
    logic                  overflow_reg;

    // Bucket index: the first hash step registers the quotient from a reciprocal multiplication
    // and the second hash step registers the remainder from it.
    assign prod = PROD_W'(mag_reg) * PROD_W'(RECIP);
    assign diff = mag_reg - quot_reg * BUCKETS_K;

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= key;
            mag_reg <= key[KEY_W-1] ? (~key + 1'b1) : key;
        end
        else if (cmd.hash_step)
        begin
            quot_reg <= KEY_W'(prod >> SHIFT);
            rem_reg  <= diff[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_write)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    assign status.clear_last = (clr_reg == RW'(BUCKETS - 1));

    // Way selection: a matching valid way wins, otherwise the lowest free way.
    always_comb
    begin
        logic              found_hit;
        logic              found_free;
        logic              v;
        logic [KEY_W-1:0]  k;
        logic [COUNT_BITS-1:0] c;
        found_hit  = 1'b0;
        found_free = 1'b0;
        hit_oh     = '0;
        free_oh    = '0;
        hit_count  = '0;
        wrow       = rdata_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            v = rdata_reg[w*WAY_W + WAY_W - 1];
            k = rdata_reg[w*WAY_W + COUNT_BITS +: KEY_W];
            c = rdata_reg[w*WAY_W +: COUNT_BITS];
            if (v && (k == key_reg) && !found_hit)
            begin
                found_hit = 1'b1;
                hit_oh[w] = 1'b1;
                hit_count = (c == '1) ? c : c + 1'b1;
            end
            if (!v && !found_free)
            begin
                found_free = 1'b1;
                free_oh[w] = 1'b1;
            end
        end
        any_hit  = found_hit;
        any_free = found_free;
        for (int w = 0; w < WAYS; w++)
        begin
            if (hit_oh[w])
            begin
                wrow[w*WAY_W +: COUNT_BITS] = hit_count;
            end
            else if (free_oh[w] && !found_hit)
            begin
                wrow[w*WAY_W +: WAY_W] = {1'b1, key_reg, COUNT_BITS'(1)};
            end
        end
    end

    generate
        if (COUNT_BITS > OUT_W)
        begin : g_clip
            assign hit_count_out = (|hit_count[COUNT_BITS-1:OUT_W]) ? '1
                                                                   : hit_count[OUT_W-1:0];
        end
        else
        begin : g_ext
            assign hit_count_out = OUT_W'(hit_count);
        end
    endgenerate

    assign we    = cmd.clear_write || (cmd.update && (any_hit || any_free));
    assign waddr = cmd.clear_write ? clr_reg : rem_reg;
    assign wdata = cmd.clear_write ? '0 : wrow;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.mem_read)
        begin
            rdata_reg <= mem[rem_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (any_hit)
            begin
                count_reg    <= hit_count_out;
                is_new_reg   <= 1'b0;
                overflow_reg <= 1'b0;
            end
            else if (any_free)
            begin
                count_reg    <= OUT_W'(1);
                is_new_reg   <= 1'b1;
                overflow_reg <= 1'b0;
            end
            else
            begin
                count_reg    <= '0;
                is_new_reg   <= 1'b0;
                overflow_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign count    = count_reg;
    assign is_new   = is_new_reg;
    assign overflow = overflow_reg;

endmodule

// File: src/hash_frequency_counter.sv
`timescale 1ns / 1ps
// Result: the result of an accepted word is marked by done for one cycle; done, count,
// is_new and overflow are all registered from the update state.
// Sequence: the bucket index takes the hash steps of reciprocal multiplication, then one
// bucket memory read and one update step; a new word is taken only when busy is low.
// Reset: after rst_n is released the bucket memory is cleared one bucket per cycle
// with busy high; done is never held off by the receiver.

module hash_frequency_counter #(
    parameter int BUCKETS    = 1021,
    parameter int WAYS       = 4,
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] key,
    output logic        busy,
    output logic        done,
    output logic [31:0] count,
    output logic        is_new,
    output logic        overflow
);

    import hfc_pkg::*;

    cmd_t    cmd;
    status_t status;

    hfc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    hfc_dp #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .key      (key),
        .done     (done),
        .count    (count),
        .is_new   (is_new),
        .overflow (overflow)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import hfc_pkg::*;

    localparam int BUCKETS    = 1021;
    localparam int WAYS       = 4;
    localparam int COUNT_BITS = 32;
    localparam int ENTRIES    = BUCKETS * WAYS;
    localparam int PROBES     = 21;
    localparam int RANDOM_WORDS = 400;
    localparam int REPEAT_WORDS = 30;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 24;

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [OUT_W-1:0] count;
        logic             is_new;
        logic             overflow;
    } tally_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             typed;
        tally_t           want;
    } probe_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [KEY_W-1:0] key = '0;
    logic             busy;
    logic             done;
    logic [OUT_W-1:0] count;
    logic             is_new;
    logic             overflow;

    logic                  entry_used [ENTRIES];
    logic [KEY_W-1:0]      entry_key [ENTRIES];
    logic [COUNT_BITS-1:0] entry_tally [ENTRIES];

    tally_t           pending_tallies [$];
    logic [KEY_W-1:0] seen_keys [$];
    int               error_count = 0;
    int               quiet_cycles = 0;
    bit               no_idle = 1'b0;

    // A full bucket is built in bucket 0; 2^31 falls in bucket 54 and 2^31 - 1 in bucket 53.
    probe_t probe_tab [PROBES] = '{
        '{32'd0,           1'b1, '{32'd1, 1'b1, 1'b0}},
        '{32'd0,           1'b1, '{32'd2, 1'b0, 1'b0}},
        '{KEY_MAX,         1'b1, '{32'd1, 1'b1, 1'b0}},
        '{KEY_MIN,         1'b1, '{32'd1, 1'b1, 1'b0}},
        '{32'hFFFF_FFFF,   1'b1, '{32'd1, 1'b1, 1'b0}},
        '{32'd1,           1'b1, '{32'd1, 1'b1, 1'b0}},
        '{32'hFFFF_FFFF,   1'b1, '{32'd2, 1'b0, 1'b0}},
        '{KEY_MIN,         1'b1, '{32'd2, 1'b0, 1'b0}},
        '{32'd1021,        1'b1, '{32'd1, 1'b1, 1'b0}},
        '{32'(-1021),      1'b1, '{32'd1, 1'b1, 1'b0}},
        '{32'd2042,        1'b1, '{32'd1, 1'b1, 1'b0}},
        '{32'd3063,        1'b1, '{32'd0, 1'b0, 1'b1}},
        '{32'(-2042),      1'b1, '{32'd0, 1'b0, 1'b1}},
        '{32'd0,           1'b1, '{32'd3, 1'b0, 1'b0}},
        '{32'd2042,        1'b1, '{32'd2, 1'b0, 1'b0}},
        '{KEY_MAX,         1'b1, '{32'd2, 1'b0, 1'b0}},
        '{32'h8000_0001,   1'b1, '{32'd1, 1'b1, 1'b0}},
        '{32'hAAAA_AAAA,   1'b0, '{32'd0, 1'b0, 1'b0}},
        '{32'h5555_5555,   1'b0, '{32'd0, 1'b0, 1'b0}},
        '{32'd3063,        1'b1, '{32'd0, 1'b0, 1'b1}},
        '{32'h8000_0001,   1'b1, '{32'd2, 1'b0, 1'b0}}
    };

    hash_frequency_counter #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .key      (key),
        .busy     (busy),
        .done     (done),
        .count    (count),
        .is_new   (is_new),
        .overflow (overflow)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic tally_t count_occurrence(input logic [KEY_W-1:0] k);
        tally_t           r;
        logic [KEY_W-1:0] mag;
        logic [63:0]      wide;
        int               base;
        int               hit;
        int               free_way;
        int               i;
        mag = k[KEY_W-1] ? (~k + 1'b1) : k;
        base = int'(mag % 32'(BUCKETS)) * WAYS;
        hit = -1;
        free_way = -1;
        for (int w = 0; w < WAYS; w++)
        begin
            if (entry_used[base + w])
            begin
                if (hit < 0 && entry_key[base + w] == k)
                    hit = w;
            end
            else if (free_way < 0)
            begin
                free_way = w;
            end
        end
        r = '0;
        if (hit >= 0)
        begin
            i = base + hit;
            if (entry_tally[i] != '1)
                entry_tally[i] = entry_tally[i] + 1'b1;
            wide = 64'(entry_tally[i]);
            r.count = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
        end
        else if (free_way >= 0)
        begin
            i = base + free_way;
            entry_used[i] = 1'b1;
            entry_key[i] = k;
            entry_tally[i] = COUNT_BITS'(1);
            r.count = 32'd1;
            r.is_new = 1'b1;
        end
        else
        begin
            r.overflow = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int unsigned      sel;
        sel = $urandom_range(0, 99);
        if (sel < 40 && seen_keys.size() > 0)
        begin
            k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
        end
        else if (sel < 65)
        begin
            // A handful of hot buckets so that they fill up and overflow.
            k = $urandom_range(0, 7) * 97 + $urandom_range(0, 6) * BUCKETS;
            if ($urandom_range(0, 1) == 1)
                k = -k;
        end
        else if (sel < 85)
        begin
            k = $urandom();
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: k = KEY_MIN;
                1: k = KEY_MAX;
                2: k = KEY_MIN + 1'b1;
                3: k = '1;
                4: k = 32'd1;
                default: k = '0;
            endcase
        end
        return k;
    endfunction

    task automatic send_word(input logic [KEY_W-1:0] k, input logic typed, input tally_t want);
        tally_t predicted;
        int     gap;
        if ($urandom_range(0, 24) == 0)
            no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        key <= k;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = count_occurrence(k);
        pending_tallies.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_tallies.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        tally_t want;
        if ((rst_n && start && busy === 1'b0) || done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && done === 1'b1)
        begin
            if (pending_tallies.size() == 0)
            begin
                $display("%0t: result with no word pending: count %0d is_new %0b overflow %0b",
                         $time, count, is_new, overflow);
                error_count++;
            end
            else
            begin
                want = pending_tallies.pop_front();
                if (count !== want.count)
                begin
                    $display("%0t: count expected %0d actual %0d", $time, want.count, count);
                    error_count++;
                end
                if (is_new !== want.is_new)
                begin
                    $display("%0t: is_new expected %0b actual %0b", $time, want.is_new, is_new);
                    error_count++;
                end
                if (overflow !== want.overflow)
                begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want.overflow, overflow);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [KEY_W-1:0] k;
        foreach (entry_used[i])
            entry_used[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (probe_tab[i])
            send_word(probe_tab[i].key, probe_tab[i].typed, probe_tab[i].want);
        drain_results();

        // One key repeated many times in a row.
        for (int n = 0; n < REPEAT_WORDS; n++)
            send_word(32'h0000_1234, 1'b0, '0);
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            k = pick_key();
            send_word(k, 1'b0, '0);
            seen_keys.push_back(k);
            if (seen_keys.size() > 48)
                void'(seen_keys.pop_front());
            if ($urandom_range(0, 49) == 0)
                drain_results();
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
